// ===== design/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/crcdf_pkg.sv =====
// Shared types and constants of the CRC-16 framed byte deframer.
`timescale 1ns / 1ps
`default_nettype none
package crcdf_pkg;

    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 8;
    localparam int LIMIT_W = 7;

    localparam logic [CFG_AW-1:0] CFG_SOF_FIRST  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SOF_SECOND = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_LIMIT      = 2'd2;

    localparam logic [7:0]         SOF_FIRST_RST  = 8'hAA;
    localparam logic [7:0]         SOF_SECOND_RST = 8'h55;
    localparam logic [LIMIT_W-1:0] LIMIT_RST      = 7'd64;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [3:0] {
        ST_SOF_A,
        ST_SOF_B,
        ST_ID,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_DATA,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef enum logic [1:0] {
        FS_GOOD     = 2'd0,
        FS_CRC_ERR  = 2'd1,
        FS_OVERSIZE = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic          crc_init;
        logic          crc_feed;
        logic          cap_id;
        logic          cap_len_lo;
        logic          cap_len_hi;
        logic          store_byte;
        logic          cap_crc_lo;
        logic          load_status;
        frame_status_t status;
        logic          rd_start;
        logic          rd_issue;
        logic          load_data;
    } dp_cmd_t;

    typedef struct packed {
        logic sof_first_hit;
        logic sof_second_hit;
        logic over_limit;
        logic new_len_zero;
        logic held_len_zero;
        logic data_done;
        logic crc_match;
        logic crc_busy;
        logic out_free;
        logic rd_last;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/crc16_framed_byte_deframer_top.sv =====
// Top level of the CRC-16 framed byte deframer.
// Id, length and payload bytes: no new request until the previous byte's CRC bit steps end.
// Start-of-frame and CRC bytes: one request per cycle while CRC and output slot are free.
// Status result: registered at the edge that accepts the deciding byte, visible next cycle.
// Good payload burst: each byte is read in EMIT_RD, then output in EMIT_WR when out_free.
// Synchronous active-low reset clears control and config; payload memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module crc16_framed_byte_deframer_top #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [crcdf_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [crcdf_pkg::CFG_DW-1:0] cfg_wdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,  // rx_byte
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [31:0]                       m_tdata,  // message_id, frame_length, data_byte
    output logic [2:0]                        m_tuser,  // frame_status, data_valid
    output logic                              m_tlast
);
    import crcdf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    crcdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    crcdf_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (s_tdata),
        .cmd_i     (cmd),
        .stat_o    (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// ===== design/crcdf_dp.sv =====
// Datapath of the deframer: configuration, header fields, bit-serial CRC, payload memory, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module crcdf_dp #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [crcdf_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [crcdf_pkg::CFG_DW-1:0]  cfg_wdata,
    input  wire logic [7:0]                    rx_byte,
    input  wire crcdf_pkg::dp_cmd_t            cmd_i,
    output crcdf_pkg::dp_stat_t                stat_o,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,  // message_id, frame_length, data_byte
    output logic [2:0]                         m_tuser,  // frame_status, data_valid
    output logic                               m_tlast
);
    import crcdf_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LIMIT_W-1:0] MAX_LIM = LIMIT_W'(MAX_PAYLOAD);

    logic [7:0]         sof_first_reg;
    logic [7:0]         sof_second_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [7:0]       id_reg;
    logic [15:0]      len_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [7:0]       crc_lo_reg;
    logic [15:0]      crc_reg;
    logic             crc_busy_reg;
    logic [2:0]       bit_cnt_reg;
    logic [7:0]       rdata_reg;
    logic [7:0]       mem [MAX_PAYLOAD];

    logic             m_tvalid_reg;
    frame_status_t    out_status_reg;
    logic [7:0]       out_id_reg;
    logic [15:0]      out_len_reg;
    logic [7:0]       out_data_reg;
    logic             out_dvalid_reg;
    logic             out_last_reg;

    logic [15:0]        new_len;
    logic [15:0]        len_full;
    logic [LIMIT_W-1:0] lim_eff;
    logic [CNT_W-1:0]   len_cnt;
    logic               out_free;

    function automatic logic [15:0] crc_shift(input logic [15:0] c);
        crc_shift = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    endfunction

    assign new_len  = {rx_byte, len_reg[7:0]};
    assign len_full = cmd_i.cap_len_hi ? new_len : len_reg;
    assign lim_eff  = (limit_reg > MAX_LIM) ? MAX_LIM : limit_reg;
    assign len_cnt  = len_reg[CNT_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        stat_o.sof_first_hit  = (rx_byte == sof_first_reg);
        stat_o.sof_second_hit = (rx_byte == sof_second_reg);
        stat_o.over_limit     = (new_len > 16'(lim_eff));
        stat_o.new_len_zero   = (new_len == 16'd0);
        stat_o.held_len_zero  = (len_reg == 16'd0);
        stat_o.data_done      = ((idx_reg + CNT_W'(1)) == len_cnt);
        stat_o.crc_match      = ({rx_byte, crc_lo_reg} == crc_reg);
        stat_o.crc_busy       = crc_busy_reg;
        stat_o.out_free       = out_free;
        stat_o.rd_last        = ((rd_idx_reg + CNT_W'(1)) == len_cnt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sof_first_reg  <= SOF_FIRST_RST;
            sof_second_reg <= SOF_SECOND_RST;
            limit_reg      <= LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SOF_FIRST:  sof_first_reg  <= cfg_wdata;
                CFG_SOF_SECOND: sof_second_reg <= cfg_wdata;
                CFG_LIMIT:      limit_reg      <= cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // One CRC bit per cycle; the first bit is taken in the cycle the byte arrives.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_busy_reg <= 1'b0;
            bit_cnt_reg  <= 3'd0;
        end else if (cmd_i.crc_feed) begin
            crc_busy_reg <= 1'b1;
            bit_cnt_reg  <= 3'd7;
        end else if (crc_busy_reg) begin
            bit_cnt_reg <= bit_cnt_reg - 3'd1;
            if (bit_cnt_reg == 3'd1) begin
                crc_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.crc_init) begin
            crc_reg <= CRC_INIT;
        end else if (cmd_i.crc_feed) begin
            crc_reg <= crc_shift(crc_reg ^ {rx_byte, 8'h00});
        end else if (crc_busy_reg) begin
            crc_reg <= crc_shift(crc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.cap_id) begin
            id_reg <= rx_byte;
        end
        if (cmd_i.cap_len_lo) begin
            len_reg <= {8'h00, rx_byte};
        end
        if (cmd_i.cap_len_hi) begin
            len_reg <= new_len;
            idx_reg <= '0;
        end
        if (cmd_i.store_byte) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (cmd_i.cap_crc_lo) begin
            crc_lo_reg <= rx_byte;
        end
        if (cmd_i.rd_start) begin
            rd_idx_reg <= '0;
        end else if (cmd_i.load_data) begin
            rd_idx_reg <= rd_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.store_byte) begin
            mem[idx_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (cmd_i.rd_issue) begin
            rdata_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.load_status || cmd_i.load_data) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_status) begin
            out_status_reg <= cmd_i.status;
            out_id_reg     <= id_reg;
            out_len_reg    <= len_full;
            out_data_reg   <= 8'h00;
            out_dvalid_reg <= 1'b0;
            out_last_reg   <= 1'b1;
        end else if (cmd_i.load_data) begin
            out_status_reg <= FS_GOOD;
            out_id_reg     <= id_reg;
            out_len_reg    <= len_reg;
            out_data_reg   <= rdata_reg;
            out_dvalid_reg <= 1'b1;
            out_last_reg   <= stat_o.rd_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_data_reg, out_len_reg, out_id_reg};
    assign m_tuser  = {out_dvalid_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    `ASSERT_NOW(a_feed_when_idle, aclk, aresetn, cmd_i.crc_feed, !crc_busy_reg)
    `ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd_i.load_status || cmd_i.load_data, out_free)
    `ASSERT_NOW(a_store_in_frame, aclk, aresetn, cmd_i.store_byte, 16'(idx_reg) < len_reg)

endmodule
`default_nettype wire

// ===== design/crcdf_ctrl.sv =====
// Controller of the deframer: frame phase state machine and burst sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module crcdf_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire crcdf_pkg::dp_stat_t  stat_i,
    output crcdf_pkg::dp_cmd_t        cmd_o
);
    import crcdf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   in_phase;
    logic   acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SOF_A;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = in_phase && !stat_i.crc_busy && stat_i.out_free;
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        in_phase   = 1'b1;
        case (state_reg)
            ST_SOF_A: begin
                if (acc && stat_i.sof_first_hit) begin
                    state_next = ST_SOF_B;
                end
            end
            ST_SOF_B: begin
                if (acc) begin
                    if (stat_i.sof_second_hit) begin
                        cmd_o.crc_init = 1'b1;
                        state_next     = ST_ID;
                    end else begin
                        state_next = ST_SOF_A;
                    end
                end
            end
            ST_ID: begin
                if (acc) begin
                    cmd_o.cap_id   = 1'b1;
                    cmd_o.crc_feed = 1'b1;
                    state_next     = ST_LEN_LO;
                end
            end
            ST_LEN_LO: begin
                if (acc) begin
                    cmd_o.cap_len_lo = 1'b1;
                    cmd_o.crc_feed   = 1'b1;
                    state_next       = ST_LEN_HI;
                end
            end
            ST_LEN_HI: begin
                if (acc) begin
                    cmd_o.cap_len_hi = 1'b1;
                    cmd_o.crc_feed   = 1'b1;
                    if (stat_i.over_limit) begin
                        cmd_o.load_status = 1'b1;
                        cmd_o.status      = FS_OVERSIZE;
                        state_next        = ST_SOF_A;
                    end else if (stat_i.new_len_zero) begin
                        state_next = ST_CRC_LO;
                    end else begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (acc) begin
                    cmd_o.store_byte = 1'b1;
                    cmd_o.crc_feed   = 1'b1;
                    if (stat_i.data_done) begin
                        state_next = ST_CRC_LO;
                    end
                end
            end
            ST_CRC_LO: begin
                if (acc) begin
                    cmd_o.cap_crc_lo = 1'b1;
                    state_next       = ST_CRC_HI;
                end
            end
            ST_CRC_HI: begin
                if (acc) begin
                    if (!stat_i.crc_match) begin
                        cmd_o.load_status = 1'b1;
                        cmd_o.status      = FS_CRC_ERR;
                        state_next        = ST_SOF_A;
                    end else if (stat_i.held_len_zero) begin
                        cmd_o.load_status = 1'b1;
                        cmd_o.status      = FS_GOOD;
                        state_next        = ST_SOF_A;
                    end else begin
                        cmd_o.rd_start = 1'b1;
                        state_next     = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD: begin
                in_phase       = 1'b0;
                cmd_o.rd_issue = 1'b1;
                state_next     = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                in_phase = 1'b0;
                if (stat_i.out_free) begin
                    cmd_o.load_data = 1'b1;
                    state_next      = stat_i.rd_last ? ST_SOF_A : ST_EMIT_RD;
                end
            end
            default: begin
                in_phase   = 1'b0;
                state_next = ST_SOF_A;
            end
        endcase
    end

    `ASSERT_NEXT(a_emit_waits, aclk, aresetn,
        (state_reg == ST_EMIT_WR) && !stat_i.out_free, state_reg == ST_EMIT_WR)
    `ASSERT_NEXT(a_good_frame_emits, aclk, aresetn,
        (state_reg == ST_CRC_HI) && acc && stat_i.crc_match && !stat_i.held_len_zero,
        state_reg == ST_EMIT_RD)
    `ASSERT_NOW(a_no_request_in_burst, aclk, aresetn,
        (state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_WR), !s_tready)

endmodule
`default_nettype wire

// ===== tb/crc16_framed_byte_deframer_top_tb.sv =====
// Self-checking testbench for the CRC-16 framed byte deframer top level.
`timescale 1ns / 1ps
module crc16_framed_byte_deframer_top_tb;
    import crcdf_pkg::*;

    localparam int EFF_MAX      = 64;
    localparam int DRAIN_CYCLES = 24;
    localparam int END_CYCLES   = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [2:0] {
        HUNT_A,
        HUNT_B,
        GET_ID,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_DATA,
        GET_CRC_LO,
        GET_CRC_HI
    } rx_phase_t;

    typedef struct {
        frame_status_t status;
        logic [7:0]    id;
        logic [15:0]   len;
        logic [7:0]    data;
        logic          valid;
        logic          last;
    } frame_word_t;

    typedef enum {RK_BYTE, RK_CRC_LO, RK_CRC_HI, RK_CRC_BAD, RK_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CFG_AW-1:0] addr;
        logic [7:0]        value;
        bit                typed;
        frame_word_t       word;
    } stim_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'h00;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;
    logic [2:0]        m_tuser;
    logic              m_tlast;

    int idle_pct   = 10;
    int mismatches = 0;
    int cycles     = 0;

    logic [7:0]  sof_first_q;
    logic [7:0]  sof_second_q;
    logic [6:0]  limit_q;
    rx_phase_t   ph;
    logic [7:0]  id_q;
    logic [15:0] len_q;
    logic [6:0]  idx_q;
    logic [15:0] crc_q;
    logic [7:0]  crc_lo_q;
    logic [7:0]  store_q [EFF_MAX];

    frame_word_t deframed_q [$];
    frame_word_t step_words [$];
    frame_word_t seen_want;
    stim_row_t   directed_rows [$];

    crc16_framed_byte_deframer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic frame_word_t word_of(frame_status_t st, logic [7:0] d, logic v, logic l);
        frame_word_t w;
        w.status = st;
        w.id     = id_q;
        w.len    = len_q;
        w.data   = d;
        w.valid  = v;
        w.last   = l;
        return w;
    endfunction

    function void deframe_byte(logic [7:0] b);
        int lim;
        int n;
        step_words.delete();
        case (ph)
            HUNT_A: begin
                if (b == sof_first_q) ph = HUNT_B;
            end
            HUNT_B: begin
                if (b == sof_second_q) begin
                    ph = GET_ID;
                    crc_q = CRC_INIT;
                end else begin
                    ph = HUNT_A;
                end
            end
            GET_ID: begin
                id_q = b;
                crc_q = crc16_step(crc_q, b);
                ph = GET_LEN_LO;
            end
            GET_LEN_LO: begin
                len_q = {8'h00, b};
                crc_q = crc16_step(crc_q, b);
                ph = GET_LEN_HI;
            end
            GET_LEN_HI: begin
                len_q[15:8] = b;
                crc_q = crc16_step(crc_q, b);
                idx_q = '0;
                lim = (limit_q > EFF_MAX) ? EFF_MAX : limit_q;
                if (len_q > lim) begin
                    step_words.push_back(word_of(FS_OVERSIZE, 8'h00, 1'b0, 1'b1));
                    ph = HUNT_A;
                end else begin
                    ph = (len_q != 0) ? GET_DATA : GET_CRC_LO;
                end
            end
            GET_DATA: begin
                if (idx_q < EFF_MAX) store_q[idx_q] = b;
                crc_q = crc16_step(crc_q, b);
                idx_q = idx_q + 7'd1;
                if (idx_q >= len_q || idx_q >= EFF_MAX) ph = GET_CRC_LO;
            end
            GET_CRC_LO: begin
                crc_lo_q = b;
                ph = GET_CRC_HI;
            end
            default: begin
                if ({b, crc_lo_q} != crc_q) begin
                    step_words.push_back(word_of(FS_CRC_ERR, 8'h00, 1'b0, 1'b1));
                end else if (len_q == 0) begin
                    step_words.push_back(word_of(FS_GOOD, 8'h00, 1'b0, 1'b1));
                end else begin
                    n = (len_q > EFF_MAX) ? EFF_MAX : len_q;
                    for (int i = 0; i < n; i++) begin
                        step_words.push_back(word_of(FS_GOOD, store_q[i], 1'b1, i == n - 1));
                    end
                end
                ph = HUNT_A;
            end
        endcase
    endfunction

    function void add_row(row_kind_t k, logic [CFG_AW-1:0] a, logic [7:0] v);
        stim_row_t r;
        r.kind  = k;
        r.addr  = a;
        r.value = v;
        r.typed = 1'b0;
        directed_rows.push_back(r);
    endfunction

    function void add_byte(logic [7:0] v);
        add_row(RK_BYTE, '0, v);
    endfunction

    function void add_typed(row_kind_t k, logic [7:0] v, frame_status_t st, logic [7:0] id,
                            logic [15:0] len);
        stim_row_t r;
        r.kind       = k;
        r.addr       = '0;
        r.value      = v;
        r.typed      = 1'b1;
        r.word.status = st;
        r.word.id    = id;
        r.word.len   = len;
        r.word.data  = 8'h00;
        r.word.valid = 1'b0;
        r.word.last  = 1'b1;
        directed_rows.push_back(r);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(b);
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_byte(b);
        foreach (step_words[i]) deframed_q.push_back(step_words[i]);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [7:0] data);
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            CFG_SOF_FIRST:  sof_first_q  = data;
            CFG_SOF_SECOND: sof_second_q = data;
            CFG_LIMIT:      limit_q      = data[6:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [7:0] f, input logic [7:0] s, input logic [7:0] lim_w,
                             input int budget, input bit full_first);
        int sent;
        int eff;
        int len;
        int c;
        bit first;
        bit hit_lo;
        logic [7:0] flip;
        write_reg(CFG_SOF_FIRST, f);
        write_reg(CFG_SOF_SECOND, s);
        write_reg(CFG_LIMIT, lim_w);
        eff = (limit_q > EFF_MAX) ? EFF_MAX : limit_q;
        sent = 0;
        first = full_first;
        while (sent < budget) begin
            c = $urandom_range(99);
            if (!first && c < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(8'($urandom_range(255)));
                    sent++;
                end
            end else if (!first && c < 14) begin
                send_byte(f);
                send_byte($urandom_range(1) ? f : 8'($urandom_range(255)));
                sent += 2;
            end else begin
                c = $urandom_range(99);
                if (first) len = eff;
                else if (c < 10) len = eff + 1;
                else if (c < 15) len = $urandom_range(256, 65535);
                else if (c < 19) len = eff;
                else if (c < 27) len = 0;
                else len = $urandom_range(0, (eff < 8) ? eff : 8);
                first = 1'b0;
                send_byte(f);
                send_byte(s);
                send_byte(8'($urandom_range(255)));
                send_byte(len[7:0]);
                send_byte(len[15:8]);
                sent += 5;
                if (len <= eff) begin
                    repeat (len) begin
                        send_byte(8'($urandom_range(255)));
                        sent++;
                    end
                    flip = ($urandom_range(99) < 80) ? 8'h00 : 8'($urandom_range(1, 255));
                    hit_lo = $urandom_range(1);
                    send_byte(crc_q[7:0] ^ (hit_lo ? flip : 8'h00));
                    send_byte(crc_q[15:8] ^ (hit_lo ? 8'h00 : flip));
                    sent += 2;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("crc16_framed_byte_deframer_top_tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (deframed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result: status %0d id %h len %h data %h valid %b last %b",
                             $time, m_tuser[1:0], m_tdata[7:0], m_tdata[23:8], m_tdata[31:24],
                             m_tuser[2], m_tlast);
                end
            end else begin
                seen_want = deframed_q.pop_front();
                if (m_tuser[1:0] !== seen_want.status || m_tdata[7:0] !== seen_want.id ||
                    m_tdata[23:8] !== seen_want.len || m_tdata[31:24] !== seen_want.data ||
                    m_tuser[2] !== seen_want.valid || m_tlast !== seen_want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch: expected status %0d id %h len %h data %h valid %b last %b",
                                 $time, seen_want.status, seen_want.id, seen_want.len,
                                 seen_want.data, seen_want.valid, seen_want.last);
                        $display("%0t:           got status %0d id %h len %h data %h valid %b last %b",
                                 $time, m_tuser[1:0], m_tdata[7:0], m_tdata[23:8], m_tdata[31:24],
                                 m_tuser[2], m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        stim_row_t row;
        logic [7:0] v;

        sof_first_q  = SOF_FIRST_RST;
        sof_second_q = SOF_SECOND_RST;
        limit_q      = LIMIT_RST;
        ph           = HUNT_A;
        id_q         = 8'h00;
        len_q        = 16'h0000;
        idx_q        = '0;
        crc_q        = CRC_INIT;
        crc_lo_q     = 8'h00;

        // Out-of-range register index, then the largest length under the reset settings.
        add_row(RK_CFG, CFG_SPARE, 8'hFF);
        add_byte(8'hAA);
        add_byte(8'h55);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_typed(RK_BYTE, 8'hFF, FS_OVERSIZE, 8'h00, 16'hFFFF);
        // A wrong second start byte must not be taken as a new first start byte.
        add_byte(8'hAA);
        add_byte(8'hAA);
        add_byte(8'h55);
        add_byte(8'hAA);
        add_byte(8'h55);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'h00);
        add_row(RK_CRC_LO, '0, 8'h00);
        add_typed(RK_CRC_HI, 8'h00, FS_GOOD, 8'hFF, 16'h0000);
        // The limit is taken when the high length byte arrives.
        add_byte(8'hAA);
        add_byte(8'h55);
        add_byte(8'h5A);
        add_byte(8'h01);
        add_row(RK_CFG, CFG_LIMIT, 8'h00);
        add_typed(RK_BYTE, 8'h00, FS_OVERSIZE, 8'h5A, 16'h0001);
        add_row(RK_CFG, CFG_LIMIT, 8'h7F);
        add_byte(8'hAA);
        add_byte(8'h55);
        add_byte(8'hFF);
        add_byte(8'h01);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_row(RK_CRC_LO, '0, 8'h00);
        add_typed(RK_CRC_BAD, 8'h00, FS_CRC_ERR, 8'hFF, 16'h0001);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            v = row.value;
            case (row.kind)
                RK_CRC_LO:  v = crc_q[7:0];
                RK_CRC_HI:  v = crc_q[15:8];
                RK_CRC_BAD: v = ~crc_q[15:8];
                default: ;
            endcase
            if (row.kind == RK_CFG) begin
                write_reg(row.addr, row.value);
            end else if (row.typed) begin
                push_byte(v);
                deframed_q.push_back(row.word);
            end else begin
                send_byte(v);
            end
        end

        run_phase(8'hAA, 8'h55, 8'd64, 70, 1'b0);
        idle_pct = 0;
        run_phase(8'h00, 8'hFF, 8'd127, 100, 1'b1);
        idle_pct = 10;
        run_phase(8'hFF, 8'h00, 8'd0, 30, 1'b0);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(1, 63)), 70, 1'b0);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  {1'b1, 7'($urandom_range(127))}, 70, 1'b1);

        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (mismatches == 0 && deframed_q.size() == 0) begin
            $display("crc16_framed_byte_deframer_top_tb: PASS");
        end else begin
            $display("crc16_framed_byte_deframer_top_tb: FAIL");
        end
        $finish;
    end

endmodule
